@@ hw/rtl/csv_cell_tokenizer_macros.svh @@
// ----------------------------------------------------------------------------
// csv_cell_tokenizer_macros.svh
// Assertion macros shared by the CSV cell tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef CSV_CELL_TOKENIZER_MACROS_SVH
`define CSV_CELL_TOKENIZER_MACROS_SVH

`ifndef ASSERT_OFF

// The property must hold at every clock edge outside reset.
`define CTOK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define CTOK_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define CTOK_ASSERT(lbl, clk, rst_n, prop, msg)
`define CTOK_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

@@ hw/rtl/ctok_pkg.sv @@
// ----------------------------------------------------------------------------
// ctok_pkg
// Types, constants and helpers shared by the CSV cell tokenizer modules.
// ----------------------------------------------------------------------------
package ctok_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int OUT_W       = 32;

  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] SEP_RESET  = 8'd44;

  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  typedef enum logic [5:0] {
    MODE_START = 6'b000001,
    MODE_NLRUN = 6'b000010,
    MODE_PLAIN = 6'b000100,
    MODE_QSEEN = 6'b001000,
    MODE_INQ   = 6'b010000,
    MODE_HALT  = 6'b100000
  } mode_e;

  typedef enum logic [1:0] {
    KIND_CELL = 2'd0,
    KIND_REC  = 2'd1,
    KIND_BAD  = 2'd2,
    KIND_OPEN = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [OUT_W-1:0] offset;
    logic [OUT_W-1:0] length;
    logic             last;
  } result_t;

  // Results produced by one step: cnt is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic [OUT_W-1:0] to_out(input logic [OFFSET_BITS-1:0] v);
    logic [OFFSET_BITS+OUT_W-1:0] ext;
    ext = {{OUT_W{1'b0}}, v};
    return ext[OUT_W-1:0];
  endfunction

  function automatic result_t make_res(input kind_e k,
                                       input logic [OFFSET_BITS-1:0] off,
                                       input logic [OFFSET_BITS-1:0] len);
    result_t r;
    r.kind   = k;
    r.offset = to_out(off);
    r.length = to_out(len);
    r.last   = 1'b0;
    return r;
  endfunction

endpackage

@@ hw/rtl/ctok_core.sv @@
// ----------------------------------------------------------------------------
// ctok_core
// Scan state and the per-byte step logic of the CSV cell tokenizer.
// ----------------------------------------------------------------------------
module ctok_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          data_byte_i,
  input  logic                flush_i,
  input  logic [7:0]          separator_i,
  output ctok_pkg::push_t     push_o
);

  ctok_pkg::mode_e                    mode_q, mode_d;
  logic [ctok_pkg::OFFSET_BITS-1:0]   pos_q, pos_d;
  logic [ctok_pkg::OFFSET_BITS-1:0]   begin_q, begin_d;
  logic                               aftsep_q, aftsep_d;

  logic                               is_q, is_nl, is_sep, start_path;
  logic [ctok_pkg::OFFSET_BITS-1:0]   run_len;
  ctok_pkg::push_t                    push;

  localparam logic [ctok_pkg::OFFSET_BITS-1:0] ZERO = '0;

  assign is_q    = (data_byte_i == ctok_pkg::CHAR_QUOTE);
  assign is_nl   = (data_byte_i == ctok_pkg::CHAR_LF) || (data_byte_i == ctok_pkg::CHAR_CR);
  assign is_sep  = (data_byte_i == separator_i);
  assign run_len = pos_q - begin_q;

  // A non-newline byte in a newline run behaves like a byte at a cell start.
  assign start_path = (mode_q == ctok_pkg::MODE_START) ||
                      ((mode_q == ctok_pkg::MODE_NLRUN) && !is_nl);

  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    begin_d  = begin_q;
    aftsep_d = aftsep_q;
    push     = '0;

    if (step_i && flush_i) begin
      case (mode_q)
        ctok_pkg::MODE_START: begin
          if (aftsep_q) begin
            push.r0  = ctok_pkg::make_res(ctok_pkg::KIND_CELL, pos_q, ZERO);
            push.r1  = ctok_pkg::make_res(ctok_pkg::KIND_REC, ZERO, ZERO);
            push.cnt = 2'd2;
          end
          aftsep_d = 1'b0;
        end
        ctok_pkg::MODE_NLRUN: begin
          mode_d   = ctok_pkg::MODE_START;
          aftsep_d = 1'b0;
        end
        ctok_pkg::MODE_PLAIN, ctok_pkg::MODE_QSEEN: begin
          push.r0  = ctok_pkg::make_res(ctok_pkg::KIND_CELL, begin_q, run_len);
          push.r1  = ctok_pkg::make_res(ctok_pkg::KIND_REC, ZERO, ZERO);
          push.cnt = 2'd2;
          mode_d   = ctok_pkg::MODE_START;
          aftsep_d = 1'b0;
        end
        ctok_pkg::MODE_INQ: begin
          push.r0  = ctok_pkg::make_res(ctok_pkg::KIND_OPEN, begin_q, ZERO);
          push.cnt = 2'd1;
          mode_d   = ctok_pkg::MODE_START;
          aftsep_d = 1'b0;
        end
        default: begin
        end
      endcase
    end else if (step_i) begin
      // Offsets stop advancing once the scanner has halted.
      if (mode_q != ctok_pkg::MODE_HALT) begin
        pos_d = pos_q + 1'b1;
      end
      if (start_path) begin
        if (is_q) begin
          begin_d  = pos_q;
          aftsep_d = 1'b0;
          mode_d   = ctok_pkg::MODE_INQ;
        end else if (is_sep) begin
          push.r0  = ctok_pkg::make_res(ctok_pkg::KIND_CELL, pos_q, ZERO);
          push.cnt = 2'd1;
          aftsep_d = 1'b1;
          mode_d   = ctok_pkg::MODE_START;
        end else if (is_nl) begin
          push.r0  = ctok_pkg::make_res(ctok_pkg::KIND_CELL, pos_q, ZERO);
          push.r1  = ctok_pkg::make_res(ctok_pkg::KIND_REC, ZERO, ZERO);
          push.cnt = 2'd2;
          aftsep_d = 1'b0;
          mode_d   = ctok_pkg::MODE_NLRUN;
        end else begin
          begin_d  = pos_q;
          aftsep_d = 1'b0;
          mode_d   = ctok_pkg::MODE_PLAIN;
        end
      end else begin
        case (mode_q)
          ctok_pkg::MODE_PLAIN: begin
            if (is_nl) begin
              push.r0  = ctok_pkg::make_res(ctok_pkg::KIND_CELL, begin_q, run_len);
              push.r1  = ctok_pkg::make_res(ctok_pkg::KIND_REC, ZERO, ZERO);
              push.cnt = 2'd2;
              mode_d   = ctok_pkg::MODE_NLRUN;
            end else if (is_sep) begin
              push.r0  = ctok_pkg::make_res(ctok_pkg::KIND_CELL, begin_q, run_len);
              push.cnt = 2'd1;
              aftsep_d = 1'b1;
              mode_d   = ctok_pkg::MODE_START;
            end
          end
          ctok_pkg::MODE_INQ: begin
            if (is_q) begin
              mode_d = ctok_pkg::MODE_QSEEN;
            end
          end
          ctok_pkg::MODE_QSEEN: begin
            if (is_q) begin
              mode_d = ctok_pkg::MODE_INQ;
            end else if (is_nl) begin
              push.r0  = ctok_pkg::make_res(ctok_pkg::KIND_CELL, begin_q, run_len);
              push.r1  = ctok_pkg::make_res(ctok_pkg::KIND_REC, ZERO, ZERO);
              push.cnt = 2'd2;
              aftsep_d = 1'b0;
              mode_d   = ctok_pkg::MODE_NLRUN;
            end else if (is_sep) begin
              push.r0  = ctok_pkg::make_res(ctok_pkg::KIND_CELL, begin_q, run_len);
              push.cnt = 2'd1;
              aftsep_d = 1'b1;
              mode_d   = ctok_pkg::MODE_START;
            end else begin
              push.r0  = ctok_pkg::make_res(ctok_pkg::KIND_BAD, pos_q, ZERO);
              push.cnt = 2'd1;
              mode_d   = ctok_pkg::MODE_HALT;
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (push.cnt == 2'd1) begin
      push.r0.last = 1'b1;
    end
    if (push.cnt == 2'd2) begin
      push.r1.last = 1'b1;
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ctok_pkg::MODE_START;
      pos_q    <= '0;
      begin_q  <= '0;
      aftsep_q <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      begin_q  <= begin_d;
      aftsep_q <= aftsep_d;
    end
  end

endmodule

@@ hw/rtl/ctok_rq.sv @@
// ----------------------------------------------------------------------------
// ctok_rq
// Result queue: takes up to two results per cycle, hands out one per cycle while the reader is ready.
// ----------------------------------------------------------------------------
module ctok_rq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctok_pkg::push_t     push_i,
  output logic                room_o,
  output logic                valid_o,
  input  logic                ready_i,
  output ctok_pkg::result_t   head_o
);

  ctok_pkg::result_t                  mem_q [ctok_pkg::RQ_DEPTH];
  logic [ctok_pkg::RQ_PTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [ctok_pkg::RQ_PTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [ctok_pkg::RQ_CNT_W-1:0]      cnt_q, cnt_d;
  logic [ctok_pkg::RQ_PTR_W-1:0]      wr_ptr_nx;
  logic                               pop;

  localparam logic [ctok_pkg::RQ_CNT_W-1:0] ROOM_MAX =
    ctok_pkg::RQ_CNT_W'(ctok_pkg::RQ_DEPTH - 2);

  assign valid_o   = (cnt_q != '0);
  assign head_o    = mem_q[rd_ptr_q];
  assign pop       = valid_o && ready_i;
  // Room for a full two-result step, without counting on a pop this cycle.
  assign room_o    = (cnt_q <= ROOM_MAX);
  assign wr_ptr_nx = wr_ptr_q + 1'b1;

  always_comb begin
    wr_ptr_d = wr_ptr_q + ctok_pkg::RQ_PTR_W'(push_i.cnt);
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + ctok_pkg::RQ_CNT_W'(push_i.cnt) - ctok_pkg::RQ_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

@@ hw/rtl/csv_cell_tokenizer.sv @@
// ----------------------------------------------------------------------------
// csv_cell_tokenizer
// Splits a CSV byte stream into cell descriptors (offset, length) and record
// ends, with a configurable separator.
// ----------------------------------------------------------------------------
// The block takes one byte (or a flush) per cycle, unless a full result queue
// stalls it, into an input register and scans it once the queue has room for a
// full step. Each item yields zero, one or two results; the four-entry result
// queue hands out one result per cycle while the output is ready, so the
// sustained rate is one item per cycle as long as items average at most one
// result, and otherwise is set by the queue draining one result per cycle.
// The separator register may be written only while no item is in flight.
`include "csv_cell_tokenizer_macros.svh"

module csv_cell_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        sep_we_i,
  input  logic [7:0]  separator_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        flush_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [31:0] cell_offset_o,
  output logic [31:0] cell_length_o,
  output logic        last_of_run_o
);

  logic [7:0]         sep_q;
  logic               s1_valid_q, s1_valid_d;
  logic [7:0]         s1_byte_q;
  logic               s1_flush_q;
  logic               advance, room, take;
  ctok_pkg::push_t    push;
  ctok_pkg::result_t  head;

  assign advance    = s1_valid_q && room;
  assign in_ready_o = !s1_valid_q || advance;
  assign take       = in_valid_i && in_ready_o;
  assign s1_valid_d = take || (s1_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q      <= ctok_pkg::SEP_RESET;
      s1_valid_q <= 1'b0;
    end else begin
      if (sep_we_i) begin
        sep_q <= separator_i;
      end
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_byte_q  <= data_byte_i;
      s1_flush_q <= flush_i;
    end
  end

  ctok_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .data_byte_i (s1_byte_q),
    .flush_i     (s1_flush_q),
    .separator_i (sep_q),
    .push_o      (push)
  );

  ctok_rq u_rq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .head_o  (head)
  );

  assign kind_o        = head.kind;
  assign cell_offset_o = head.offset;
  assign cell_length_o = head.length;
  assign last_of_run_o = head.last;

  `CTOK_ASSERT_NEVER(a_push_without_step, clk_i, rst_ni, !advance && (push.cnt != 2'd0),
    "results produced without a scanned item")
  `CTOK_ASSERT(a_first_of_two_is_cell, clk_i, rst_ni,
    (out_valid_o && !last_of_run_o) |-> (kind_o == ctok_pkg::KIND_CELL),
    "non-final result is not a cell")
  `CTOK_ASSERT(a_len_zero_non_cell, clk_i, rst_ni,
    (out_valid_o && (kind_o != ctok_pkg::KIND_CELL)) |-> (cell_length_o == '0),
    "non-cell result has a length")
  `CTOK_ASSERT(a_rec_end_fields, clk_i, rst_ni,
    (out_valid_o && (kind_o == ctok_pkg::KIND_REC)) |-> ((cell_offset_o == '0) && last_of_run_o),
    "record end malformed")

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking testbench for the CSV cell tokenizer.
// ----------------------------------------------------------------------------
// A short table of hand-picked bytes covers the scanner corners: separators
// and newlines at a cell start, quoted cells with escapes, newline runs,
// flushes in every mode short of a halt and separators that collide with quote or newline.
// Random CSV records then follow under several separators, with random stalls
// on both channels, and the run ends with a bad byte after a closing quote.
// Every result is compared with a typed table row or the bench's own tokenizer.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ctok_pkg::*;

  localparam int RESET_CYCLES = 7;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 120;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int MAX_REPORTS  = 10;
  localparam int PHASE_ITEMS  = 86;
  localparam int FROM_MODEL   = -1;
  localparam result_t NO_RES  = '0;

  typedef enum logic {ROW_ITEM, ROW_SEP} row_op_e;

  typedef struct {
    row_op_e    op;
    logic [7:0] data;
    logic       flush;
    int         n_typed;
    result_t    r0;
    result_t    r1;
  } row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        sep_we_i    = 1'b0;
  logic [7:0]  separator_i = 8'h00;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  data_byte_i = 8'h00;
  logic        flush_i     = 1'b0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  kind_o;
  logic [31:0] cell_offset_o;
  logic [31:0] cell_length_o;
  logic        last_of_run_o;

  csv_cell_tokenizer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sep_we_i     (sep_we_i),
    .separator_i  (separator_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .flush_i      (flush_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .cell_offset_o(cell_offset_o),
    .cell_length_o(cell_length_o),
    .last_of_run_o(last_of_run_o)
  );

  always #2 clk_i = ~clk_i;

  // Tokenizer state as the bench sees it.
  mode_e       tok_mode      = MODE_START;
  logic [31:0] tok_pos       = '0;
  logic [31:0] tok_begin     = '0;
  logic        tok_after_sep = 1'b0;
  logic [7:0]  tok_sep       = SEP_RESET;

  result_t step_out[$];
  result_t expected_res[$];
  result_t typed_res[$];
  row_t    rows[$];
  result_t got, want;

  bit use_typed    = 1'b0;
  bit calm         = 1'b0;
  bit hold_pending = 1'b0;
  bit allow_bad    = 1'b0;
  int items_sent, directed_items, sep_writes, cycles;
  int results_seen, mismatches, n_cells, n_recs, n_bad, n_open;

  function automatic result_t mk_res(kind_e k, logic [31:0] off, logic [31:0] len,
                                     logic last);
    result_t r;
    r.kind   = k;
    r.offset = off;
    r.length = len;
    r.last   = last;
    return r;
  endfunction

  function automatic bit is_eol(logic [7:0] b);
    return b == CHAR_LF || b == CHAR_CR;
  endfunction

  function void emit(kind_e k, logic [31:0] off, logic [31:0] len);
    step_out.push_back(mk_res(k, off, len, 1'b0));
  endfunction

  // A byte that arrives where a new cell may begin.
  function void start_cell(logic [7:0] b);
    if (b == CHAR_QUOTE) begin
      tok_begin     = tok_pos;
      tok_after_sep = 1'b0;
      tok_mode      = MODE_INQ;
    end else if (b == tok_sep) begin
      emit(KIND_CELL, tok_pos, 0);
      tok_after_sep = 1'b1;
      tok_mode      = MODE_START;
    end else if (is_eol(b)) begin
      emit(KIND_CELL, tok_pos, 0);
      emit(KIND_REC, 0, 0);
      tok_after_sep = 1'b0;
      tok_mode      = MODE_NLRUN;
    end else begin
      tok_begin     = tok_pos;
      tok_after_sep = 1'b0;
      tok_mode      = MODE_PLAIN;
    end
  endfunction

  function void tokenize(logic [7:0] b, logic f);
    step_out.delete();
    if (tok_mode == MODE_HALT) return;
    if (f) begin
      case (tok_mode)
        MODE_START: begin
          if (tok_after_sep) begin
            emit(KIND_CELL, tok_pos, 0);
            emit(KIND_REC, 0, 0);
          end
        end
        MODE_PLAIN, MODE_QSEEN: begin
          emit(KIND_CELL, tok_begin, tok_pos - tok_begin);
          emit(KIND_REC, 0, 0);
        end
        MODE_INQ: emit(KIND_OPEN, tok_begin, 0);
        default: ;
      endcase
      tok_mode      = MODE_START;
      tok_after_sep = 1'b0;
    end else begin
      case (tok_mode)
        MODE_START: start_cell(b);
        MODE_NLRUN: begin
          if (!is_eol(b)) start_cell(b);
        end
        MODE_PLAIN: begin
          if (is_eol(b)) begin
            emit(KIND_CELL, tok_begin, tok_pos - tok_begin);
            emit(KIND_REC, 0, 0);
            tok_mode = MODE_NLRUN;
          end else if (b == tok_sep) begin
            emit(KIND_CELL, tok_begin, tok_pos - tok_begin);
            tok_after_sep = 1'b1;
            tok_mode      = MODE_START;
          end
        end
        MODE_INQ: begin
          if (b == CHAR_QUOTE) tok_mode = MODE_QSEEN;
        end
        MODE_QSEEN: begin
          if (b == CHAR_QUOTE) begin
            tok_mode = MODE_INQ;
          end else if (is_eol(b)) begin
            emit(KIND_CELL, tok_begin, tok_pos - tok_begin);
            emit(KIND_REC, 0, 0);
            tok_after_sep = 1'b0;
            tok_mode      = MODE_NLRUN;
          end else if (b == tok_sep) begin
            emit(KIND_CELL, tok_begin, tok_pos - tok_begin);
            tok_after_sep = 1'b1;
            tok_mode      = MODE_START;
          end else begin
            emit(KIND_BAD, tok_pos, 0);
            tok_mode = MODE_HALT;
          end
        end
        default: ;
      endcase
      tok_pos = tok_pos + 1;
    end
    if (step_out.size() != 0) step_out[step_out.size() - 1].last = 1'b1;
  endfunction

  // Random byte that can neither end nor split a cell.
  function automatic logic [7:0] pick_byte(bit quote_ok);
    logic [7:0] b;
    do b = 8'($urandom);
    while (is_eol(b) || b == tok_sep || (!quote_ok && b == CHAR_QUOTE));
    return b;
  endfunction

  task automatic send(logic [7:0] b, logic f);
    // Outside the final part a byte that would halt the scanner is swapped
    // for the separator, so the random stream keeps running.
    if (!allow_bad && !f && tok_mode == MODE_QSEEN && b != CHAR_QUOTE && !is_eol(b)
        && b != tok_sep)
      b = tok_sep;
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    flush_i     <= f;
    do @(posedge clk_i); while (!in_ready_o);
    tokenize(b, f);
    if (use_typed) begin
      foreach (typed_res[i]) expected_res.push_back(typed_res[i]);
    end else begin
      foreach (step_out[i]) expected_res.push_back(step_out[i]);
    end
    items_sent++;
    if (!calm && !hold_pending && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_res.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_sep(logic [7:0] v);
    sep_we_i    <= 1'b1;
    separator_i <= v;
    @(posedge clk_i);
    sep_we_i <= 1'b0;
    tok_sep = v;
    sep_writes++;
  endtask

  task automatic run_phase(logic [7:0] sep, bit long_hold, int n);
    int first, cells, len;
    logic [7:0] b;
    settle();
    write_sep(sep);
    hold_pending = long_hold;
    first = items_sent;
    while (items_sent - first < n) begin
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 6)) send(8'($urandom), $urandom_range(0, 5) == 0);
        end
        1: begin
          // Quoted cell still open when the data ends.
          send(CHAR_QUOTE, 1'b0);
          repeat ($urandom_range(0, 3)) send(pick_byte(1'b0), 1'b0);
          send(8'($urandom), 1'b1);
        end
        default: begin
          cells = $urandom_range(1, 5);
          for (int c = 0; c < cells; c++) begin
            if (c != 0) send(tok_sep, 1'b0);
            case ($urandom_range(0, 3))
              0: ;
              1, 2: begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) send(pick_byte(i != 0), 1'b0);
              end
              default: begin
                send(CHAR_QUOTE, 1'b0);
                repeat ($urandom_range(0, 6)) begin
                  case ($urandom_range(0, 5))
                    0: b = tok_sep;
                    1: b = $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
                    2: b = CHAR_QUOTE;
                    default: b = 8'($urandom);
                  endcase
                  send(b, 1'b0);
                  if (b == CHAR_QUOTE) send(b, 1'b0);
                end
                send(CHAR_QUOTE, 1'b0);
              end
            endcase
          end
          case ($urandom_range(0, 4))
            0: send(CHAR_CR, 1'b0);
            1: send(CHAR_LF, 1'b0);
            2: begin
              send(CHAR_CR, 1'b0);
              send(CHAR_LF, 1'b0);
            end
            3: repeat ($urandom_range(2, 4)) send($urandom_range(0, 1) ? CHAR_CR : CHAR_LF, 1'b0);
            default: send(8'($urandom), 1'b1);
          endcase
        end
      endcase
    end
  endtask

  // Result side: random stalls, plus one long hold-off that fills the block.
  initial begin
    wait (rst_ni);
    forever begin
      if (hold_pending) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_pending = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = mk_res(kind_e'(kind_o), cell_offset_o, cell_length_o, last_of_run_o);
      results_seen++;
      if (expected_res.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: kind %0d offset %0d length %0d last %0b",
                   got.kind, got.offset, got.length, got.last);
      end else begin
        want = expected_res.pop_front();
        case (want.kind)
          KIND_CELL: n_cells++;
          KIND_REC:  n_recs++;
          KIND_BAD:  n_bad++;
          default:   n_open++;
        endcase
        if (got.kind != want.kind || got.offset != want.offset
            || got.length != want.length || got.last != want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %0d: expected kind %0d offset %0d length %0d last %0b, %s",
                     results_seen, want.kind, want.offset, want.length, want.last,
                     $sformatf("got kind %0d offset %0d length %0d last %0b",
                               got.kind, got.offset, got.length, got.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles,
               expected_res.size());
      $display("csv_cell_tokenizer regression: fail");
      $finish;
    end
  end

  initial begin
    // Reset separator is the comma.
    rows.push_back('{ROW_ITEM, ",", 1'b0, 1, mk_res(KIND_CELL, 0, 0, 1'b1), NO_RES});
    // Flush right after a separator; its byte is ignored even if it is one.
    rows.push_back('{ROW_ITEM, ",", 1'b1, 2, mk_res(KIND_CELL, 1, 0, 1'b0),
                     mk_res(KIND_REC, 0, 0, 1'b1)});
    rows.push_back('{ROW_ITEM, "a", 1'b0, FROM_MODEL, NO_RES, NO_RES});
    rows.push_back('{ROW_ITEM, ",", 1'b0, FROM_MODEL, NO_RES, NO_RES});
    // Quoted cell holding a separator and an escaped quote.
    rows.push_back('{ROW_ITEM, CHAR_QUOTE, 1'b0, FROM_MODEL, NO_RES, NO_RES});
    rows.push_back('{ROW_ITEM, ",", 1'b0, FROM_MODEL, NO_RES, NO_RES});
    rows.push_back('{ROW_ITEM, CHAR_QUOTE, 1'b0, FROM_MODEL, NO_RES, NO_RES});
    rows.push_back('{ROW_ITEM, CHAR_QUOTE, 1'b0, FROM_MODEL, NO_RES, NO_RES});
    rows.push_back('{ROW_ITEM, CHAR_QUOTE, 1'b0, FROM_MODEL, NO_RES, NO_RES});
    rows.push_back('{ROW_ITEM, CHAR_CR, 1'b0, FROM_MODEL, NO_RES, NO_RES});
    rows.push_back('{ROW_ITEM, CHAR_LF, 1'b0, FROM_MODEL, NO_RES, NO_RES});
    rows.push_back('{ROW_ITEM, 8'hFF, 1'b0, FROM_MODEL, NO_RES, NO_RES});
    rows.push_back('{ROW_ITEM, 8'h00, 1'b0, FROM_MODEL, NO_RES, NO_RES});
    rows.push_back('{ROW_ITEM, 8'h00, 1'b1, 2, mk_res(KIND_CELL, 10, 2, 1'b0),
                     mk_res(KIND_REC, 0, 0, 1'b1)});
    rows.push_back('{ROW_ITEM, CHAR_QUOTE, 1'b0, FROM_MODEL, NO_RES, NO_RES});
    rows.push_back('{ROW_ITEM, 8'hFF, 1'b1, 1, mk_res(KIND_OPEN, 12, 0, 1'b1), NO_RES});
    rows.push_back('{ROW_ITEM, CHAR_LF, 1'b0, 2, mk_res(KIND_CELL, 13, 0, 1'b0),
                     mk_res(KIND_REC, 0, 0, 1'b1)});
    rows.push_back('{ROW_ITEM, 8'h00, 1'b1, 0, NO_RES, NO_RES});
    rows.push_back('{ROW_ITEM, CHAR_QUOTE, 1'b0, FROM_MODEL, NO_RES, NO_RES});
    rows.push_back('{ROW_ITEM, CHAR_QUOTE, 1'b0, FROM_MODEL, NO_RES, NO_RES});
    rows.push_back('{ROW_ITEM, 8'h00, 1'b1, FROM_MODEL, NO_RES, NO_RES});
    // With LF as separator, a cell start sees the separator before the newline.
    rows.push_back('{ROW_SEP, CHAR_LF, 1'b0, FROM_MODEL, NO_RES, NO_RES});
    rows.push_back('{ROW_ITEM, CHAR_LF, 1'b0, 1, mk_res(KIND_CELL, 16, 0, 1'b1), NO_RES});
    rows.push_back('{ROW_ITEM, "x", 1'b0, FROM_MODEL, NO_RES, NO_RES});
    rows.push_back('{ROW_ITEM, CHAR_LF, 1'b0, FROM_MODEL, NO_RES, NO_RES});
    // With the quote as separator, a cell start opens a quoted cell.
    rows.push_back('{ROW_SEP, CHAR_QUOTE, 1'b0, FROM_MODEL, NO_RES, NO_RES});
    rows.push_back('{ROW_ITEM, CHAR_QUOTE, 1'b0, FROM_MODEL, NO_RES, NO_RES});
    rows.push_back('{ROW_ITEM, CHAR_QUOTE, 1'b0, FROM_MODEL, NO_RES, NO_RES});
    rows.push_back('{ROW_ITEM, CHAR_CR, 1'b0, FROM_MODEL, NO_RES, NO_RES});

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].op == ROW_SEP) begin
        settle();
        write_sep(rows[i].data);
      end else begin
        use_typed = rows[i].n_typed != FROM_MODEL;
        typed_res.delete();
        if (rows[i].n_typed >= 1) typed_res.push_back(rows[i].r0);
        if (rows[i].n_typed >= 2) typed_res.push_back(rows[i].r1);
        send(rows[i].data, rows[i].flush);
      end
    end
    use_typed = 1'b0;
    directed_items = items_sent;

    run_phase(8'h00, 1'b1, PHASE_ITEMS);
    run_phase(8'hFF, 1'b0, PHASE_ITEMS);
    run_phase(8'h09, 1'b0, PHASE_ITEMS);
    run_phase(CHAR_CR, 1'b0, PHASE_ITEMS);
    run_phase(8'($urandom), 1'b0, PHASE_ITEMS);
    calm = 1'b1;
    run_phase(SEP_RESET, 1'b0, PHASE_ITEMS);

    // A byte after a closing quote halts the scanner; what follows is dropped.
    settle();
    allow_bad = 1'b1;
    send(CHAR_QUOTE, 1'b0);
    send("q", 1'b0);
    send(CHAR_QUOTE, 1'b0);
    send("z", 1'b0);
    send("a", 1'b0);
    send(CHAR_LF, 1'b0);
    send(8'h00, 1'b1);
    send(CHAR_QUOTE, 1'b0);
    settle();

    $display("%0d items (%0d from the table) under %0d separator writes, %0d results checked",
             items_sent, directed_items, sep_writes, results_seen);
    $display("%0d cells, %0d record ends, %0d unfinished quotes, %0d bad bytes, %0d mismatches",
             n_cells, n_recs, n_open, n_bad, mismatches);
    if (mismatches == 0) begin
      $display("csv_cell_tokenizer regression: pass");
    end else begin
      $display("csv_cell_tokenizer regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/ctok_pkg.sv
hw/rtl/ctok_core.sv
hw/rtl/ctok_rq.sv
hw/rtl/csv_cell_tokenizer.sv
test/testbench.sv
